[design/tspdu_pkg.sv]
// ----------------------------------------------------------------------------
// Three-step phase decoder package
// Shared types, widths and constants for the phase decode and unwrap pipeline.
// ----------------------------------------------------------------------------
package tspdu_pkg;

   localparam int PHASE_BITS     = 16;
   localparam int INTENSITY_BITS = 8;
   localparam int COUNT_BITS     = 8;
   localparam int MOD_BITS       = 8;
   localparam int UNWRAP_BITS    = 24;

   localparam int CORDIC_STEPS = 28;
   localparam int ANG_BITS     = 32;
   localparam int XY_BITS      = 34;
   localparam int XY_FRAC      = 20;
   localparam int SQRT3_BITS   = 22;
   localparam logic signed [SQRT3_BITS-1:0] SQRT3_Q20 = 22'sd1816187;

   // x = 2a - b - c and y = b - c as signed integers.
   localparam int XD_BITS = INTENSITY_BITS + 3;
   localparam int YD_BITS = INTENSITY_BITS + 1;

   // The squared magnitude stays below 2^(2*INTENSITY_BITS+3).
   localparam int SQRT_STEPS = INTENSITY_BITS + 2;
   localparam int SQ_BITS    = 2 * SQRT_STEPS;

   localparam int D_BITS   = PHASE_BITS + COUNT_BITS + 1;
   localparam int Q_BITS   = COUNT_BITS + 2;
   localparam int NUM_BITS = PHASE_BITS + COUNT_BITS + 1;

   localparam logic [ANG_BITS-1:0] TURN_TABLE [0:CORDIC_STEPS-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005
   };

   typedef struct packed {
      logic [INTENSITY_BITS-1:0] intensity_a;
      logic [INTENSITY_BITS-1:0] intensity_b;
      logic [INTENSITY_BITS-1:0] intensity_c;
      logic [PHASE_BITS-1:0]     cue_phase;
   } req_type;

   typedef struct packed {
      logic [PHASE_BITS-1:0]  wrapped_phase;
      logic [MOD_BITS-1:0]    modulation;
      logic [COUNT_BITS-1:0]  period_index;
      logic [UNWRAP_BITS-1:0] unwrapped_phase;
   } rsp_type;

   // Word passed from the phase stage to the unwrap stage.
   typedef struct packed {
      logic [PHASE_BITS-1:0] wrapped_phase;
      logic [MOD_BITS-1:0]   modulation;
      logic [PHASE_BITS-1:0] cue_phase;
   } phase_type;

endpackage

[design/tspdu_phase.sv]
// ----------------------------------------------------------------------------
// Phase stage
// Forms x and y, runs a pipelined vectoring CORDIC for the wrapped phase and a
// pipelined restoring square root for the modulation alongside it.
// ----------------------------------------------------------------------------
module tspdu_phase (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  tspdu_pkg::req_type   in_word,
   output logic                 out_valid,
   output tspdu_pkg::phase_type out_word
);
   import tspdu_pkg::*;

   typedef struct packed {
      logic signed [XY_BITS-1:0] x;
      logic signed [XY_BITS-1:0] y;
      logic [ANG_BITS-1:0]       ang;
      logic [SQ_BITS-1:0]        sq_n;
      logic [SQ_BITS-1:0]        sq_r;
      logic                      zero;
      logic [PHASE_BITS-1:0]     cue;
   } cordic_type;

   function automatic cordic_type cordic_step(input cordic_type s, input int k);
      cordic_type                r;
      logic signed [XY_BITS-1:0] xs;
      logic signed [XY_BITS-1:0] ys;
      logic [SQ_BITS-1:0]        bit_v;
      logic [SQ_BITS-1:0]        t;
      r  = s;
      xs = s.x >>> k;
      ys = s.y >>> k;
      // Rotate toward the x axis: clockwise when y is not negative.
      if (!s.y[XY_BITS-1]) begin
         r.x   = s.x + ys;
         r.y   = s.y - xs;
         r.ang = s.ang + TURN_TABLE[k];
      end else begin
         r.x   = s.x - ys;
         r.y   = s.y + xs;
         r.ang = s.ang - TURN_TABLE[k];
      end
      // The first stages also carry one digit of the square root each.
      if (k < SQRT_STEPS) begin
         bit_v = SQ_BITS'(1) << (2 * (SQRT_STEPS - 1 - k));
         t     = s.sq_r + bit_v;
         if (s.sq_n >= t) begin
            r.sq_n = s.sq_n - t;
            r.sq_r = (s.sq_r >> 1) + bit_v;
         end else begin
            r.sq_r = s.sq_r >> 1;
         end
      end
      return r;
   endfunction

   logic signed [XD_BITS-1:0] xd_ff;
   logic signed [YD_BITS-1:0] yd_ff;
   logic [PHASE_BITS-1:0]     cue_ff;
   logic                      diff_vld_ff;

   cordic_type cs_ff [0:CORDIC_STEPS];
   logic       cs_vld_ff [0:CORDIC_STEPS];
   cordic_type cs_in;

   phase_type  fin_ff;
   phase_type  fin_in;
   logic       fin_vld_ff;

   // Setup: fold the left half plane over and scale both axes.
   always_comb begin
      logic signed [YD_BITS-1:0]            yd_f;
      logic signed [XD_BITS-1:0]            xd_a;
      logic signed [2*XD_BITS-1:0]          xsq;
      logic signed [2*YD_BITS-1:0]          ysq;
      logic signed [YD_BITS+SQRT3_BITS-1:0] yprod;
      xd_a  = xd_ff[XD_BITS-1] ? -xd_ff : xd_ff;
      yd_f  = xd_ff[XD_BITS-1] ? -yd_ff : yd_ff;
      yprod = yd_f * SQRT3_Q20;
      xsq   = xd_ff * xd_ff;
      ysq   = yd_ff * yd_ff;
      cs_in.x    = XY_BITS'(xd_a) <<< XY_FRAC;
      cs_in.y    = XY_BITS'(yprod);
      cs_in.ang  = xd_ff[XD_BITS-1] ? {1'b1, {(ANG_BITS-1){1'b0}}} : '0;
      cs_in.sq_n = SQ_BITS'(xsq) + SQ_BITS'(3) * SQ_BITS'(ysq);
      cs_in.sq_r = '0;
      cs_in.zero = (xd_ff == '0) && (yd_ff == '0);
      cs_in.cue  = cue_ff;
   end

   // Round the angle to the output precision and finish the modulation.
   always_comb begin
      logic [ANG_BITS-1:0] ang_r;
      logic [SQ_BITS-1:0]  root;
      ang_r = cs_ff[CORDIC_STEPS].ang + (ANG_BITS'(1) << (ANG_BITS - 1 - PHASE_BITS));
      root  = (cs_ff[CORDIC_STEPS].sq_n > cs_ff[CORDIC_STEPS].sq_r)
              ? cs_ff[CORDIC_STEPS].sq_r + SQ_BITS'(1) : cs_ff[CORDIC_STEPS].sq_r;
      fin_in.wrapped_phase = cs_ff[CORDIC_STEPS].zero ? '0
                             : ang_r[ANG_BITS-1 -: PHASE_BITS];
      fin_in.modulation    = (root > SQ_BITS'((1 << MOD_BITS) - 1)) ? '1
                             : root[MOD_BITS-1:0];
      fin_in.cue_phase     = cs_ff[CORDIC_STEPS].cue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_vld_ff <= 1'b0;
         fin_vld_ff  <= 1'b0;
         for (int k = 0; k <= CORDIC_STEPS; k++) begin
            cs_vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         diff_vld_ff  <= in_valid;
         cs_vld_ff[0] <= diff_vld_ff;
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            cs_vld_ff[k+1] <= cs_vld_ff[k];
         end
         fin_vld_ff <= cs_vld_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xd_ff  <= XD_BITS'(2 * {3'b000, in_word.intensity_a})
                   - XD_BITS'(in_word.intensity_b) - XD_BITS'(in_word.intensity_c);
         yd_ff  <= YD_BITS'(in_word.intensity_b) - YD_BITS'(in_word.intensity_c);
         cue_ff <= in_word.cue_phase;
         cs_ff[0] <= cs_in;
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            cs_ff[k+1] <= cordic_step(cs_ff[k], k);
         end
         fin_ff <= fin_in;
      end
   end

   assign out_valid = fin_vld_ff;
   assign out_word  = fin_ff;

endmodule

[design/tspdu_unwrap.sv]
// ----------------------------------------------------------------------------
// Unwrap stage
// Derives the period index from the cue and divides the unwrapped phase by
// the period count in a pipelined restoring divider, one bit per stage.
// ----------------------------------------------------------------------------
module tspdu_unwrap (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic [tspdu_pkg::COUNT_BITS-1:0] period_count,
   input  logic                            in_valid,
   input  tspdu_pkg::phase_type            in_word,
   output logic                            out_valid,
   output tspdu_pkg::rsp_type              out_word
);
   import tspdu_pkg::*;

   typedef struct packed {
      logic [COUNT_BITS-1:0] rem;
      logic [NUM_BITS-1:0]   dvd;
      logic [PHASE_BITS-1:0] ph;
      logic [MOD_BITS-1:0]   modulation;
      logic [COUNT_BITS-1:0] q;
   } div_type;

   function automatic div_type div_step(input div_type s,
                                        input logic [COUNT_BITS-1:0] n);
      div_type               r;
      logic [COUNT_BITS:0]   t;
      logic                  qbit;
      r    = s;
      t    = {s.rem, s.dvd[NUM_BITS-1]};
      qbit = (t >= {1'b0, n});
      if (qbit) begin
         t = t - {1'b0, n};
      end
      r.rem = t[COUNT_BITS-1:0];
      r.dvd = {s.dvd[NUM_BITS-2:0], qbit};
      return r;
   endfunction

   logic [COUNT_BITS-1:0] n_eff;

   logic [PHASE_BITS+COUNT_BITS-1:0] prod_ff;
   phase_type                        p0_ff;
   logic                             p0_vld_ff;

   logic [COUNT_BITS-1:0] q_ff;
   logic [COUNT_BITS-1:0] q_in;
   phase_type             p1_ff;
   logic                  p1_vld_ff;

   div_type dv_ff [0:NUM_BITS];
   logic    dv_vld_ff [0:NUM_BITS];
   div_type dv_in;

   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_vld_ff;

   assign n_eff = (period_count == '0) ? COUNT_BITS'(1) : period_count;

   // Period index: round (cue * n - phase) to whole turns, ties to even.
   always_comb begin
      logic signed [D_BITS-1:0] d;
      logic signed [D_BITS-1:0] q_raw;
      logic signed [Q_BITS-1:0] q_r;
      logic [PHASE_BITS-1:0]    rem;
      logic                     up;
      d     = $signed({1'b0, prod_ff}) - $signed(D_BITS'(p0_ff.wrapped_phase));
      q_raw = d >>> PHASE_BITS;
      rem   = d[PHASE_BITS-1:0];
      up    = (rem > (PHASE_BITS'(1) << (PHASE_BITS - 1)))
              || ((rem == (PHASE_BITS'(1) << (PHASE_BITS - 1))) && q_raw[0]);
      q_r   = q_raw[Q_BITS-1:0] + Q_BITS'(up);
      if (q_r[Q_BITS-1]) begin
         q_in = '0;
      end else if (q_r > Q_BITS'((1 << COUNT_BITS) - 1)) begin
         q_in = '1;
      end else begin
         q_in = q_r[COUNT_BITS-1:0];
      end
   end

   always_comb begin
      dv_in.rem        = '0;
      dv_in.dvd        = NUM_BITS'({q_ff, p1_ff.wrapped_phase})
                         + NUM_BITS'(n_eff >> 1);
      dv_in.ph         = p1_ff.wrapped_phase;
      dv_in.modulation = p1_ff.modulation;
      dv_in.q          = q_ff;
   end

   always_comb begin
      rsp_in.wrapped_phase   = dv_ff[NUM_BITS].ph;
      rsp_in.modulation      = dv_ff[NUM_BITS].modulation;
      rsp_in.period_index    = dv_ff[NUM_BITS].q;
      rsp_in.unwrapped_phase = (dv_ff[NUM_BITS].dvd > NUM_BITS'((1 << UNWRAP_BITS) - 1))
                               ? '1 : dv_ff[NUM_BITS].dvd[UNWRAP_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_vld_ff  <= 1'b0;
         p1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int k = 0; k <= NUM_BITS; k++) begin
            dv_vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         p0_vld_ff    <= in_valid;
         p1_vld_ff    <= p0_vld_ff;
         dv_vld_ff[0] <= p1_vld_ff;
         for (int k = 0; k < NUM_BITS; k++) begin
            dv_vld_ff[k+1] <= dv_vld_ff[k];
         end
         rsp_vld_ff <= dv_vld_ff[NUM_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= in_word.cue_phase * n_eff;
         p0_ff    <= in_word;
         q_ff     <= q_in;
         p1_ff    <= p0_ff;
         dv_ff[0] <= dv_in;
         for (int k = 0; k < NUM_BITS; k++) begin
            dv_ff[k+1] <= div_step(dv_ff[k], n_eff);
         end
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_vld_ff;
   assign out_word  = rsp_ff;

endmodule

[design/three_step_phase_decode_unwrap.sv]
// ----------------------------------------------------------------------------
// Three-step phase decode and unwrap
// Per-pixel wrapped phase, modulation and cue-based unwrapping.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock while the output is not stalled
// and returns one result word per pixel, in order. The pipeline depth comes
// mainly from the 28-stage CORDIC for the wrapped phase and the 25-stage
// restoring divider that scales the unwrapped phase by the period count.
// The whole pipeline advances together: while a result waits at the output,
// nothing moves and req_ready is low. Write the period count through
// csr_wr_data only while no pixel is in flight; a count of zero acts as one.
module three_step_phase_decode_unwrap (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  tspdu_pkg::req_type              req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tspdu_pkg::rsp_type              rsp_word,
   input  logic                            csr_wr_en,
   input  logic [tspdu_pkg::COUNT_BITS-1:0] csr_wr_data
);
   import tspdu_pkg::*;

   logic [COUNT_BITS-1:0] period_count_ff;
   logic                  en;
   logic                  ph_valid;
   phase_type             ph_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_count_ff <= COUNT_BITS'(1);
      end else if (csr_wr_en) begin
         period_count_ff <= csr_wr_data;
      end
   end

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   tspdu_phase u_phase (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_word   (req_word),
      .out_valid (ph_valid),
      .out_word  (ph_word)
   );

   tspdu_unwrap u_unwrap (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .period_count (period_count_ff),
      .in_valid     (ph_valid),
      .in_word      (ph_word),
      .out_valid    (rsp_valid),
      .out_word     (rsp_word)
   );

   // A stalled result must hold back the input side.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while output stalled");

   // Zero modulation only comes from the zero vector, whose phase is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.modulation == '0 |-> rsp_word.wrapped_phase == '0)
      else $error("zero modulation with nonzero phase");

   // Reset empties the pipeline and restores a period count of one.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && period_count_ff == COUNT_BITS'(1))
      else $error("reset state wrong");

endmodule
